[design/rhb_pkg.sv]
// ----------------------------------------------------------------------------
// rhb_pkg: shared types and constants for the ramped H-bridge speed block
// Request codes, register indexes, duty scaling constants and the state type.
// ----------------------------------------------------------------------------
package rhb_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_COAST = 2'd2,
		REQ_BRAKE = 2'd3
	} req_t;

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAMP_INTERVAL = 2'd0,
		CFG_INVERT_DIR    = 2'd1
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [15:0] RAMP_INTERVAL_RST = 16'd2;

	localparam logic signed [7:0]  SPEED_MAX8  = 8'sd100;
	localparam logic signed [15:0] SPEED_MAX16 = 16'sd100;
	localparam logic signed [15:0] SPEED_MIN16 = -16'sd100;

	// Full-scale duty and the reciprocal that replaces the divide by 100.
	// DUTY_K is rounded up so the 16-bit shift truncates exactly for |speed| <= 128.
	localparam longint unsigned DUTY_MAX = 255;
	localparam longint unsigned DUTY_K   = (DUTY_MAX * 65536 + 99) / 100;
	localparam int unsigned     DUTY_KW  = $clog2(DUTY_K + 1);
	localparam int unsigned     DUTY_FRAC = 16;
	localparam int unsigned     PROD_W   = DUTY_KW + 24;
	localparam logic [7:0]      DUTY_BRAKE = (DUTY_MAX > 255) ? 8'hFF : 8'(DUTY_MAX);

	typedef struct packed {
		logic signed [7:0] goal;
		logic signed [7:0] ramped;
		logic [15:0]       elapsed;
		logic              brake;
	} state_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

[design/rhb_state.sv]
// ----------------------------------------------------------------------------
// rhb_state: speed ramp state and configuration registers
// Holds goal speed, ramped speed, the elapsed counter and the brake flag, and
// computes the state that follows one request.
// ----------------------------------------------------------------------------
module rhb_state (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [1:0]              req_type,
	input  logic signed [15:0]      speed_value,
	input  rhb_pkg::cfg_wr_t        cfg,
	output rhb_pkg::state_t         state_nxt,
	output logic                    invert_dir
);

	rhb_pkg::state_t   state_q;
	logic [15:0]       ramp_interval_q;
	logic              invert_q;
	logic [15:0]       elapsed_inc;
	logic signed [7:0] goal_clamped;

	always_comb begin
		if (state_q.elapsed != 16'hFFFF)
			elapsed_inc = state_q.elapsed + 16'd1;
		else
			elapsed_inc = state_q.elapsed;

		if (speed_value < rhb_pkg::SPEED_MIN16)
			goal_clamped = -rhb_pkg::SPEED_MAX8;
		else if (speed_value > rhb_pkg::SPEED_MAX16)
			goal_clamped = rhb_pkg::SPEED_MAX8;
		else
			goal_clamped = speed_value[7:0];
	end

	always_comb begin
		state_nxt = state_q;
		unique case (rhb_pkg::req_t'(req_type))
			rhb_pkg::REQ_TICK: begin
				state_nxt.elapsed = elapsed_inc;
				// A step clears the counter and releases any held brake.
				if (state_q.ramped != state_q.goal && elapsed_inc >= ramp_interval_q) begin
					state_nxt.elapsed = '0;
					state_nxt.brake   = 1'b0;
					if (state_q.ramped < state_q.goal)
						state_nxt.ramped = state_q.ramped + 8'sd1;
					else
						state_nxt.ramped = state_q.ramped - 8'sd1;
				end
			end
			rhb_pkg::REQ_SET: begin
				state_nxt.goal = goal_clamped;
			end
			rhb_pkg::REQ_COAST: begin
				state_nxt.goal   = '0;
				state_nxt.ramped = '0;
				state_nxt.brake  = 1'b0;
			end
			rhb_pkg::REQ_BRAKE: begin
				state_nxt.goal   = '0;
				state_nxt.ramped = '0;
				state_nxt.brake  = 1'b1;
			end
			default: state_nxt = state_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= '0;
			ramp_interval_q <= rhb_pkg::RAMP_INTERVAL_RST;
			invert_q        <= 1'b0;
		end else if (cfg.we) begin
			case (rhb_pkg::cfg_idx_t'(cfg.index))
				rhb_pkg::CFG_RAMP_INTERVAL: ramp_interval_q <= cfg.data;
				rhb_pkg::CFG_INVERT_DIR: begin
					invert_q      <= cfg.data[0];
					state_q.brake <= 1'b0;
				end
				default: ;
			endcase
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	assign invert_dir = invert_q;

endmodule

[design/rhb_duty.sv]
// ----------------------------------------------------------------------------
// rhb_duty: bridge duty mapping
// Scales the signed speed to a duty on one bridge side, or full on both while
// the brake is held.
// ----------------------------------------------------------------------------
module rhb_duty (
	input  logic signed [7:0] ramped,
	input  logic              brake,
	input  logic              invert_dir,
	output logic [7:0]        duty_a,
	output logic [7:0]        duty_b
);

	logic signed [7:0]           eff;
	logic [7:0]                  mag;
	logic [rhb_pkg::PROD_W-1:0]  prod;
	logic [rhb_pkg::PROD_W-rhb_pkg::DUTY_FRAC-1:0] scaled;
	logic [7:0]                  duty;

	always_comb begin
		eff    = invert_dir ? -ramped : ramped;
		mag    = eff[7] ? 8'(-eff) : 8'(eff);
		// Multiply by the fixed-point reciprocal of 100 instead of dividing.
		prod   = rhb_pkg::PROD_W'(mag) * rhb_pkg::PROD_W'(rhb_pkg::DUTY_K);
		scaled = prod[rhb_pkg::PROD_W-1:rhb_pkg::DUTY_FRAC];
		duty   = (scaled > 255) ? 8'hFF : scaled[7:0];

		if (brake) begin
			duty_a = rhb_pkg::DUTY_BRAKE;
			duty_b = rhb_pkg::DUTY_BRAKE;
		end else if (!eff[7]) begin
			duty_a = duty;
			duty_b = 8'd0;
		end else begin
			duty_a = 8'd0;
			duty_b = duty;
		end
	end

endmodule

[design/ramped_hbridge_pwm_speed.sv]
// ----------------------------------------------------------------------------
// ramped_hbridge_pwm_speed: ramped H-bridge PWM speed controller
// Turns tick, target, coast and brake requests into bridge duties.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries one request (req_type, speed_value) and yields
// exactly one output transfer with duty_a, duty_b, present_speed and braking.
// A request is registered on acceptance; when it advances, the speed state
// is updated and the result is registered, and out_valid rises. One request
// is taken per cycle while no stall holds it: the throughput is one item
// per clock, set by the single state update path between the two registers.
// When out_stall is high with a result waiting, the input register holds its
// item and in_stall rises; nothing is dropped and the pipeline resumes at
// full rate once the stall clears.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// request is in flight. Writes to unlisted indexes are ignored.
// Reset clears the speeds, the elapsed counter and the brake, sets the ramp
// interval to 2 tick requests and clears the direction inversion; no clearing pass.
// ----------------------------------------------------------------------------
module ramped_hbridge_pwm_speed (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [15:0]            speed_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    duty_a,
	output logic [7:0]                    duty_b,
	output logic signed [7:0]             present_speed,
	output logic                          braking,
	input  logic                          cfg_we,
	input  logic [rhb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rhb_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic               valid_s1;
	logic [1:0]         req_type_s1;
	logic signed [15:0] speed_value_s1;
	logic               advance;
	logic               in_xfer;
	logic               out_valid_q;
	logic [7:0]         duty_a_q;
	logic [7:0]         duty_b_q;
	logic signed [7:0]  speed_q;
	logic               braking_q;
	rhb_pkg::cfg_wr_t   cfg;
	rhb_pkg::state_t    state_nxt;
	logic               invert_dir;
	logic [7:0]         duty_a_nxt;
	logic [7:0]         duty_b_nxt;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// The registered item moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_xfer)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_type_s1    <= req_type;
			speed_value_s1 <= speed_value;
		end
	end

	rhb_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.req_type    (req_type_s1),
		.speed_value (speed_value_s1),
		.cfg         (cfg),
		.state_nxt   (state_nxt),
		.invert_dir  (invert_dir)
	);

	rhb_duty u_duty (
		.ramped     (state_nxt.ramped),
		.brake      (state_nxt.brake),
		.invert_dir (invert_dir),
		.duty_a     (duty_a_nxt),
		.duty_b     (duty_b_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_a_q  <= duty_a_nxt;
			duty_b_q  <= duty_b_nxt;
			speed_q   <= state_nxt.ramped;
			braking_q <= state_nxt.brake;
		end
	end

	assign out_valid     = out_valid_q;
	assign duty_a        = duty_a_q;
	assign duty_b        = duty_b_q;
	assign present_speed = speed_q;
	assign braking       = braking_q;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item did not produce a result");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (present_speed >= -8'sd100 && present_speed <= 8'sd100))
		else $error("present speed out of range");

	a_brake_duties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && braking) |-> (duty_a == rhb_pkg::DUTY_BRAKE &&
			duty_b == rhb_pkg::DUTY_BRAKE && present_speed == 8'sd0))
		else $error("brake result without full duties");

	a_one_side_driven: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !braking) |-> (duty_a == 8'd0 || duty_b == 8'd0))
		else $error("both bridge sides driven outside a brake");
`endif

endmodule
